@@ hw/rtl/art_pkg.sv @@
// Shared types and constants for the acknowledgement round-trip tracker.
// No dependencies; every other file of the block but art_slot_ram imports this package.
package art_pkg;

   localparam int SLOTS   = 64;
   localparam int SLOT_W  = $clog2(SLOTS);
   localparam int CNT_W   = 7;
   localparam int SEQ_W   = 32;
   localparam int STAMP_W = 48;

   localparam logic FUNC_SEND = 1'b0;
   localparam logic FUNC_ACK  = 1'b1;

   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_FULL   = 1'b1;

   typedef struct packed {
      logic               func;
      logic [SEQ_W-1:0]   seq_num;
      logic [STAMP_W-1:0] stamp_us;
      logic               ecn_seen;
   } req_type;

   typedef struct packed {
      logic               kind;
      logic [CNT_W-1:0]   flight_count;
      logic [STAMP_W-1:0] rtt_us;
      logic [SEQ_W-1:0]   acked_seq;
      logic               last;
   } res_type;

   typedef struct packed {
      logic [SEQ_W-1:0]   seq;
      logic [CNT_W-1:0]   count;
      logic [STAMP_W-1:0] stamp;
   } slot_type;

   localparam int SLOT_BITS = $bits(slot_type);

   typedef struct packed {
      logic              wr_en;
      logic [SLOT_W-1:0] wr_addr;
      slot_type          wr_data;
      logic              rd_en;
      logic [SLOT_W-1:0] rd_addr;
   } ram_req_type;

   typedef struct packed {
      logic    vld;
      res_type res;
   } push_type;

endpackage

@@ hw/rtl/art_slot_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module art_slot_ram #(
   parameter int DEPTH  = 64,
   parameter int WIDTH  = 87,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/art_engine.sv @@
// Slot sequencer: valid bits, free-slot search, acknowledgement scan and
// result ordering. Depends on art_pkg; drives the slot RAM of the top level.
module art_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  art_pkg::req_type     item,
   input  logic                 ecn_only,
   output logic                 idle,
   output art_pkg::ram_req_type ram,
   input  art_pkg::slot_type    rd_slot,
   output art_pkg::push_type    push,
   input  logic                 push_rdy
);
   import art_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SEARCH = 5'b00010,
      ST_FULL   = 5'b00100,
      ST_SCAN   = 5'b01000,
      ST_FLUSH  = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [SLOTS-1:0]  valid_ff, valid_in;
   logic [CNT_W-1:0]  in_flight_ff, in_flight_in;
   logic [SLOT_W-1:0] start_ptr_ff, start_ptr_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [SLOT_W-1:0] tries_ff, tries_in;
   logic              iss_left_ff, iss_left_in;
   logic              eval_vld_ff, eval_vld_in;
   logic [SLOT_W-1:0] eval_idx_ff, eval_idx_in;
   logic              pend_vld_ff, pend_vld_in;
   res_type           pend_ff, pend_in;

   logic [SEQ_W-1:0]  seq_diff;
   logic              hit;
   logic              emit;
   logic              stall;
   logic [SLOT_W-1:0] next_idx;

   assign idle     = (state_ff == ST_IDLE);
   assign seq_diff = item.seq_num - rd_slot.seq;
   assign hit      = eval_vld_ff && valid_ff[eval_idx_ff] && !seq_diff[SEQ_W-1];
   assign emit     = hit && (!ecn_only || item.ecn_seen);
   assign stall    = emit && pend_vld_ff && !push_rdy;
   assign next_idx = (idx_ff == SLOT_W'(SLOTS - 1)) ? '0 : idx_ff + SLOT_W'(1);

   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      in_flight_in = in_flight_ff;
      start_ptr_in = start_ptr_ff;
      idx_in       = idx_ff;
      tries_in     = tries_ff;
      iss_left_in  = iss_left_ff;
      eval_vld_in  = eval_vld_ff;
      eval_idx_in  = eval_idx_ff;
      pend_vld_in  = pend_vld_ff;
      pend_in      = pend_ff;
      ram          = '0;
      push         = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (item.func == FUNC_SEND) begin
                  idx_in   = start_ptr_ff;
                  tries_in = '0;
                  state_in = ST_SEARCH;
               end else begin
                  idx_in      = '0;
                  iss_left_in = 1'b1;
                  eval_vld_in = 1'b0;
                  state_in    = ST_SCAN;
               end
            end
         end

         ST_SEARCH: begin
            if (!valid_ff[idx_ff]) begin
               valid_in[idx_ff]    = 1'b1;
               in_flight_in        = in_flight_ff + CNT_W'(1);
               start_ptr_in        = idx_ff;
               ram.wr_en           = 1'b1;
               ram.wr_addr         = idx_ff;
               ram.wr_data.seq     = item.seq_num;
               ram.wr_data.count   = in_flight_ff + CNT_W'(1);
               ram.wr_data.stamp   = item.stamp_us;
               state_in            = ST_IDLE;
            end else if (tries_ff == SLOT_W'(SLOTS - 1)) begin
               state_in = ST_FULL;
            end else begin
               idx_in   = next_idx;
               tries_in = tries_ff + SLOT_W'(1);
            end
         end

         ST_FULL: begin
            push.vld      = 1'b1;
            push.res.kind = KIND_FULL;
            push.res.last = 1'b1;
            if (push_rdy) begin
               state_in = ST_IDLE;
            end
         end

         ST_SCAN: begin
            if (eval_vld_ff && !stall) begin
               if (hit) begin
                  valid_in[eval_idx_ff] = 1'b0;
                  in_flight_in          = in_flight_ff - CNT_W'(1);
               end
               if (emit) begin
                  push.vld             = pend_vld_ff;
                  push.res             = pend_ff;
                  push.res.last        = 1'b0;
                  pend_vld_in          = 1'b1;
                  pend_in.kind         = KIND_SAMPLE;
                  pend_in.flight_count = rd_slot.count;
                  pend_in.rtt_us       = item.stamp_us - rd_slot.stamp;
                  pend_in.acked_seq    = rd_slot.seq;
                  pend_in.last         = 1'b0;
               end
            end
            if (!eval_vld_ff || !stall) begin
               if (iss_left_ff) begin
                  ram.rd_en   = 1'b1;
                  ram.rd_addr = idx_ff;
                  eval_vld_in = 1'b1;
                  eval_idx_in = idx_ff;
                  if (idx_ff == SLOT_W'(SLOTS - 1)) begin
                     iss_left_in = 1'b0;
                  end else begin
                     idx_in = idx_ff + SLOT_W'(1);
                  end
               end else begin
                  eval_vld_in = 1'b0;
                  state_in    = ST_FLUSH;
               end
            end
         end

         ST_FLUSH: begin
            push.vld      = pend_vld_ff;
            push.res      = pend_ff;
            push.res.last = 1'b1;
            if (!pend_vld_ff || push_rdy) begin
               pend_vld_in = 1'b0;
               state_in    = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         in_flight_ff <= '0;
         start_ptr_ff <= '0;
         iss_left_ff  <= 1'b0;
         eval_vld_ff  <= 1'b0;
         pend_vld_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         in_flight_ff <= in_flight_in;
         start_ptr_ff <= start_ptr_in;
         iss_left_ff  <= iss_left_in;
         eval_vld_ff  <= eval_vld_in;
         pend_vld_ff  <= pend_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      tries_ff    <= tries_in;
      eval_idx_ff <= eval_idx_in;
      pend_ff     <= pend_in;
   end

endmodule

@@ hw/rtl/art_out_reg.sv @@
// Result output register that frees the sequencer from the result consumer.
// Depends on art_pkg for the result type.
module art_out_reg (
   input  logic              clock,
   input  logic              reset,
   input  art_pkg::push_type push,
   output logic              push_rdy,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [87:0]       rsp_tdata,
   output logic              rsp_tlast,
   output logic              rsp_tuser
);
   import art_pkg::*;

   logic    vld_ff, vld_in;
   res_type res_ff, res_in;

   assign push_rdy = !vld_ff || rsp_tready;

   always_comb begin
      vld_in = vld_ff;
      res_in = res_ff;
      if (push_rdy) begin
         vld_in = push.vld;
         if (push.vld) begin
            res_in = push.res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = {1'b0, res_ff.acked_seq, res_ff.rtt_us, res_ff.flight_count};
   assign rsp_tlast  = res_ff.last;
   assign rsp_tuser  = res_ff.kind;

endmodule

@@ hw/rtl/ack_rtt_tracker.sv @@
// Top level of the acknowledgement round-trip tracker.
// Depends on art_pkg, art_slot_ram, art_engine and art_out_reg.
//
//   channel  direction  handshake              payload
//   req      in         req_tvalid/req_tready  tdata seq/stamp/ecn, tuser func
//   rsp      out        rsp_tvalid/rsp_tready  tdata count/rtt/seq, tuser kind, tlast
//   csr      in         csr_wen                csr_wdata = ecn_only
//
// For a data segment the free-slot search checks one slot per cycle from the start
// pointer; a full table adds a result transfer. For an acknowledgement the scan
// reads one slot RAM entry per cycle and stalls only while the output register
// is held. Reset is synchronous and clears all valid bits at once, so no clearing
// pass is needed. A new item is taken once the previous one is finished.
module ack_rtt_tracker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [87:0] req_tdata,  // seq_num[31:0], stamp_us[79:32], ecn_seen[80], zero
   input  logic        req_tuser,  // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,  // flight_count[6:0], rtt_us[54:7], acked_seq[86:55]
   output logic        rsp_tlast,
   output logic        rsp_tuser,  // kind
   input  logic        csr_wen,
   input  logic        csr_wdata
);
   import art_pkg::*;

   logic        ecn_only_ff, ecn_only_in;
   logic        start_ff, start_in;
   req_type     item_ff, item_in;
   logic        eng_idle;
   ram_req_type ram;
   logic [SLOT_BITS-1:0] rd_data;
   push_type    push;
   logic        push_rdy;
   logic        req_accept;

   assign req_tready = eng_idle && !start_ff;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      ecn_only_in = csr_wen ? csr_wdata : ecn_only_ff;
      start_in    = req_accept;
      item_in     = item_ff;
      if (req_accept) begin
         item_in.func     = req_tuser;
         item_in.seq_num  = req_tdata[SEQ_W-1:0];
         item_in.stamp_us = req_tdata[SEQ_W+STAMP_W-1:SEQ_W];
         item_in.ecn_seen = req_tdata[SEQ_W+STAMP_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ecn_only_ff <= 1'b0;
         start_ff    <= 1'b0;
      end else begin
         ecn_only_ff <= ecn_only_in;
         start_ff    <= start_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   art_slot_ram #(
      .DEPTH (SLOTS),
      .WIDTH (SLOT_BITS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram.wr_en),
      .wr_addr (ram.wr_addr),
      .wr_data (ram.wr_data),
      .rd_en   (ram.rd_en),
      .rd_addr (ram.rd_addr),
      .rd_data (rd_data)
   );

   art_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .start    (start_ff),
      .item     (item_ff),
      .ecn_only (ecn_only_ff),
      .idle     (eng_idle),
      .ram      (ram),
      .rd_slot  (slot_type'(rd_data)),
      .push     (push),
      .push_rdy (push_rdy)
   );

   art_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_rdy   (push_rdy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

@@ hw/rtl/art_checker.sv @@
// Port-level checks on the result channel of the round-trip tracker.
// Depends on art_pkg; bound to ack_rtt_tracker at the end of this file.
module art_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [87:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        rsp_tuser
);
   import art_pkg::*;

   a_reset_clears_output: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("Result valid after reset.");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("Stalled result changed.");

   a_full_form: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_FULL) |-> rsp_tlast && (rsp_tdata == '0))
      else $error("Table-full result is malformed.");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_SAMPLE) |->
         (rsp_tdata[CNT_W-1:0] != '0) && (rsp_tdata[CNT_W-1:0] <= CNT_W'(SLOTS)))
      else $error("Sample flight count out of range.");

endmodule

bind ack_rtt_tracker art_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

@@ verif/tb_top.sv @@
// Self-checking testbench for ack_rtt_tracker: it drives segment and acknowledgement
// transfers, predicts every round-trip sample and table-full result, and checks them.
// Depends on art_pkg and the ack_rtt_tracker RTL.
module tb_top;
   import art_pkg::*;

   localparam int LIMIT_CYCLES  = 1000000;
   localparam int SETTLE_CYCLES = 200;
   localparam int PHASE_ITEMS   = 18;
   localparam int BURST_SENDS   = SLOTS + 2;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [87:0] req_tdata   = '0;
   logic        req_tuser   = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [87:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;
   logic        csr_wen     = 1'b0;
   logic        csr_wdata   = 1'b0;

   req_type segments_pending[$];
   res_type rtt_due[$];

   // Shadow of the slot table and the counters.
   bit                 slot_busy[SLOTS];
   logic [SEQ_W-1:0]   slot_sn[SLOTS];
   logic [CNT_W-1:0]   slot_fc[SLOTS];
   logic [STAMP_W-1:0] slot_ts[SLOTS];
   logic [SLOT_W-1:0]  hunt_ptr    = '0;
   logic [CNT_W-1:0]   outstanding = '0;
   bit                 ecn_filter  = 1'b0;

   int  send_idle_pct  = 0;
   int  recv_stall_pct = 0;
   bit  req_taken      = 1'b0;
   int  cycle_count    = 0;
   int  error_count    = 0;
   int  items_done     = 0;
   int  results_seen   = 0;
   int  full_seen      = 0;
   int  run_len        = 0;
   int  longest_run    = 0;

   logic [SEQ_W-1:0]   snd_next;
   logic [STAMP_W-1:0] now_us;

   always #5 clock = ~clock;

   ack_rtt_tracker uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      for (int k = 0; k < SLOTS; k++) begin
         slot_busy[k] = 1'b0;
      end
   end

   function automatic logic [STAMP_W-1:0] rand48();
      logic [63:0] w;
      w = {$urandom(), $urandom()};
      return w[STAMP_W-1:0];
   endfunction

   task automatic update_rtt_table(input req_type it);
      int               i;
      bit               found;
      bit               have_held;
      res_type          held;
      res_type          full_res;
      logic [SEQ_W-1:0] diff;
      if (it.func == FUNC_SEND) begin
         found = 1'b0;
         for (int k = 0; k < SLOTS && !found; k++) begin
            i = (int'(hunt_ptr) + k) % SLOTS;
            if (!slot_busy[i]) begin
               found        = 1'b1;
               hunt_ptr     = SLOT_W'(i);
               slot_busy[i] = 1'b1;
               slot_sn[i]   = it.seq_num;
               outstanding  = outstanding + CNT_W'(1);
               slot_fc[i]   = outstanding;
               slot_ts[i]   = it.stamp_us;
            end
         end
         if (!found) begin
            full_res      = '0;
            full_res.kind = KIND_FULL;
            full_res.last = 1'b1;
            rtt_due.push_back(full_res);
         end
      end else begin
         have_held = 1'b0;
         held      = '0;
         for (int k = 0; k < SLOTS; k++) begin
            diff = it.seq_num - slot_sn[k];
            if (slot_busy[k] && !diff[SEQ_W-1]) begin
               outstanding  = outstanding - CNT_W'(1);
               slot_busy[k] = 1'b0;
               if (!ecn_filter || it.ecn_seen) begin
                  if (have_held) begin
                     rtt_due.push_back(held);
                  end
                  held.kind         = KIND_SAMPLE;
                  held.flight_count = slot_fc[k];
                  held.rtt_us       = it.stamp_us - slot_ts[k];
                  held.acked_seq    = slot_sn[k];
                  held.last         = 1'b0;
                  have_held         = 1'b1;
               end
            end
         end
         if (have_held) begin
            held.last = 1'b1;
            rtt_due.push_back(held);
         end
      end
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      error_count++;
      $display("mismatch on result %0d, %s: got %0h, want %0h", results_seen, what, got, want);
   endtask

   task automatic check_result();
      res_type want;
      if (rtt_due.size() == 0) begin
         report_mismatch("no result pending", 64'(rsp_tdata), 64'd0);
      end else begin
         want = rtt_due.pop_front();
         if (rsp_tuser !== want.kind) begin
            report_mismatch("kind", 64'(rsp_tuser), 64'(want.kind));
         end
         if (rsp_tdata[6:0] !== want.flight_count) begin
            report_mismatch("flight_count", 64'(rsp_tdata[6:0]), 64'(want.flight_count));
         end
         if (rsp_tdata[54:7] !== want.rtt_us) begin
            report_mismatch("rtt_us", 64'(rsp_tdata[54:7]), 64'(want.rtt_us));
         end
         if (rsp_tdata[86:55] !== want.acked_seq) begin
            report_mismatch("acked_seq", 64'(rsp_tdata[86:55]), 64'(want.acked_seq));
         end
         if (rsp_tlast !== want.last) begin
            report_mismatch("last", 64'(rsp_tlast), 64'(want.last));
         end
         if (want.kind == KIND_FULL) begin
            full_seen++;
         end
      end
      results_seen++;
      run_len++;
      if (run_len > longest_run) begin
         longest_run = run_len;
      end
      if (rsp_tlast === 1'b1) begin
         run_len = 0;
      end
   endtask

   // Monitor: samples both channels at the rising edge.
   always @(posedge clock) begin
      req_taken <= !reset && req_tvalid && req_tready;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            check_result();
         end
         if (req_tvalid && req_tready) begin
            update_rtt_table(segments_pending[0]);
            void'(segments_pending.pop_front());
            items_done++;
         end
      end
   end

   // Driver: changes inputs at the falling edge and holds a transfer until taken.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (segments_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata  <= {7'b0, segments_pending[0].ecn_seen,
                           segments_pending[0].stamp_us, segments_pending[0].seq_num};
            req_tuser  <= segments_pending[0].func;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_top: errors");
      $finish;
   end

   task automatic add_item(input logic func, input logic [SEQ_W-1:0] sn,
                           input logic [STAMP_W-1:0] ts, input logic ecn);
      req_type it;
      it.func     = func;
      it.seq_num  = sn;
      it.stamp_us = ts;
      it.ecn_seen = ecn;
      segments_pending.push_back(it);
   endtask

   task automatic settle();
      do begin
         @(negedge clock);
      end while (segments_pending.size() != 0 || req_tvalid || rtt_due.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic start_phase(input int send_pct, input int recv_pct, input bit ecn_mode);
      @(negedge clock);
      csr_wen    <= 1'b1;
      csr_wdata  <= ecn_mode;
      ecn_filter = ecn_mode;
      @(negedge clock);
      csr_wen    <= 1'b0;
      @(posedge clock);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   task automatic send_next_segment();
      add_item(FUNC_SEND, snd_next, now_us, 1'($urandom_range(0, 1)));
      snd_next = snd_next + $urandom_range(1, 1460);
      now_us   = now_us + STAMP_W'($urandom_range(1, 300));
   endtask

   task automatic gen_traffic(input int count);
      int r;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (r < 55) begin
            send_next_segment();
         end else if (r < 85) begin
            now_us = now_us + STAMP_W'($urandom_range(0, 5000));
            add_item(FUNC_ACK, snd_next - $urandom_range(0, 6000), now_us,
                     1'($urandom_range(0, 1)));
         end else begin
            add_item(1'($urandom_range(0, 1)), $urandom(), rand48(),
                     1'($urandom_range(0, 1)));
         end
      end
   endtask

   initial begin
      snd_next = $urandom();
      now_us   = rand48();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      start_phase(0, 0, 1'b0);
      add_item(FUNC_SEND, 32'h0000_0000, 48'h0000_0000_0000, 1'b0);
      add_item(FUNC_SEND, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1);
      add_item(FUNC_SEND, 32'h8000_0000, 48'h0000_0000_0001, 1'b0);
      add_item(FUNC_SEND, 32'h7FFF_FFFF, 48'h8000_0000_0000, 1'b0);
      add_item(FUNC_ACK,  32'h7FFF_FFFF, 48'h0000_0000_0000, 1'b0);
      add_item(FUNC_ACK,  32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1);
      add_item(FUNC_ACK,  32'h1234_5678, 48'h0000_0000_0010, 1'b1);
      add_item(FUNC_SEND, 32'h0000_1000, 48'h0000_0000_0005, 1'b0);
      add_item(FUNC_ACK,  32'h8000_1000, 48'h0000_0000_0009, 1'b0);
      add_item(FUNC_ACK,  32'h8000_0FFF, 48'h0000_0000_000C, 1'b0);
      settle();

      start_phase(0, 0, 1'b1);
      add_item(FUNC_SEND, 32'd100, 48'd10, 1'b0);
      add_item(FUNC_SEND, 32'd200, 48'd20, 1'b0);
      add_item(FUNC_ACK,  32'd150, 48'd30, 1'b0);
      add_item(FUNC_ACK,  32'd250, 48'd40, 1'b1);
      add_item(FUNC_SEND, 32'd300, 48'd50, 1'b1);
      add_item(FUNC_SEND, 32'd400, 48'd60, 1'b0);
      add_item(FUNC_ACK,  32'd400, 48'd70, 1'b0);
      settle();

      for (int p = 0; p < 8; p++) begin
         case (p % 4)
            0: begin
               start_phase(0, 0, p >= 4);
            end
            1: begin
               start_phase(63, 0, p >= 4);
            end
            2: begin
               start_phase(0, 63, p >= 4);
            end
            default: begin
               start_phase(17, 17, p >= 4);
            end
         endcase
         if (p == 2) begin
            for (int n = 0; n < BURST_SENDS; n++) begin
               send_next_segment();
            end
            add_item(FUNC_ACK, snd_next, now_us + STAMP_W'($urandom_range(0, 5000)), 1'b1);
         end
         gen_traffic(PHASE_ITEMS);
         settle();
      end

      $display("summary: %0d requests, %0d results checked, %0d of them table-full",
               items_done, results_seen, full_seen);
      $display("summary: up to %0d results from one request, both ECN filter settings",
               longest_run);
      if (error_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
